[src/url_percent_codec_assert.svh]
// Assertion macros for the URL percent codec.
`ifndef URL_PERCENT_CODEC_ASSERT_SVH
`define URL_PERCENT_CODEC_ASSERT_SVH

`ifndef SYNTH

// Check that a condition holds at every clock edge outside reset.
`define UPC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("upc assertion failed");

// Check that a condition in one cycle leads to a consequence in the next.
`define UPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("upc assertion failed");

`else

`define UPC_ASSERT_ALWAYS(label, clk, rst, cond)
`define UPC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/upc_pkg.sv]
// Shared types and constants for the URL percent codec.
`default_nettype none

package upc_pkg;

   localparam logic [7:0] CH_PERCENT    = 8'd37;
   localparam logic [7:0] CH_PLUS       = 8'd43;
   localparam logic [7:0] CH_SPACE      = 8'd32;
   localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
   localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

   localparam int unsigned MAX_BEATS = 3;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HIGH = 3'b010,
      PH_LOW  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       ok;
      logic       last;
   } beat_type;

   typedef struct packed {
      logic [1:0]                   cnt;
      beat_type [MAX_BEATS-1:0]     beat;
   } beat_set_type;

endpackage

`default_nettype wire

[src/upc_ifs.sv]
// Stream interfaces for the codec's source-byte and result channels.
`default_nettype none

interface upc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, in_byte, in_last, input ready);
   modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface upc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       out_last;

   modport source (output valid, out_byte, out_valid, out_last, input ready);
   modport sink   (input valid, out_byte, out_valid, out_last, output ready);
endinterface

`default_nettype wire

[src/upc_xlate.sv]
// Per-byte translation: result beats and next escape state for one source byte.
`default_nettype none

module upc_xlate (
   input  wire logic               decode_mode,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   input  upc_pkg::phase_type      phase,
   input  wire logic [3:0]         high_digit,
   output upc_pkg::beat_set_type   beat_set,
   output upc_pkg::phase_type      phase_next,
   output logic [3:0]              high_next
);

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] w;
      w = {4'b0000, v};
      return (v > 4'd9) ? w + upc_pkg::HEX_ALPHA_OFS : w + upc_pkg::HEX_DIGIT_OFS;
   endfunction

   // Letters count 10..35 in either case; anything that is neither a letter nor a digit counts 0.
   function automatic logic [5:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= 8'd65 && c <= 8'd90)       d = c - 8'd55;
      else if (c >= 8'd97 && c <= 8'd122) d = c - 8'd87;
      else if (c >= 8'd48 && c <= 8'd57)  d = c - 8'd48;
      return d[5:0];
   endfunction

   function automatic logic is_plain(input logic [7:0] c);
      logic p;
      p = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
          (c >= 8'd97 && c <= 8'd122);
      case (c)
         8'd45, 8'd95, 8'd46, 8'd126, 8'd61, 8'd33,
         8'd42, 8'd39, 8'd40, 8'd41, 8'd38: p = 1'b1;
         default: ;
      endcase
      return p;
   endfunction

   logic [5:0] digit;
   logic [7:0] joined;

   assign digit  = digit_value(in_byte);
   assign joined = {high_digit, 4'b0000} + {2'b00, digit};

   always_comb begin
      beat_set   = '0;
      phase_next = phase;
      high_next  = high_digit;
      if (!decode_mode) begin
         beat_set.cnt = 2'd1;
         if (is_plain(in_byte)) begin
            beat_set.beat[0] = '{data: in_byte, ok: 1'b1, last: in_last};
         end else if (in_byte == upc_pkg::CH_SPACE) begin
            beat_set.beat[0] = '{data: upc_pkg::CH_PLUS, ok: 1'b1, last: in_last};
         end else begin
            beat_set.cnt     = 2'd3;
            beat_set.beat[0] = '{data: upc_pkg::CH_PERCENT, ok: 1'b1, last: 1'b0};
            beat_set.beat[1] = '{data: hex_char(in_byte[7:4]), ok: 1'b1, last: 1'b0};
            beat_set.beat[2] = '{data: hex_char(in_byte[3:0]), ok: 1'b1, last: in_last};
         end
      end else begin
         unique case (phase)
            upc_pkg::PH_HIGH: begin
               if (in_last) begin
                  // escape cut short: one invalid closing beat
                  beat_set.cnt     = 2'd1;
                  beat_set.beat[0] = '{data: 8'd0, ok: 1'b0, last: 1'b1};
                  phase_next       = upc_pkg::PH_IDLE;
                  high_next        = 4'd0;
               end else begin
                  high_next  = digit[3:0];
                  phase_next = upc_pkg::PH_LOW;
               end
            end
            upc_pkg::PH_LOW: begin
               beat_set.cnt     = 2'd1;
               beat_set.beat[0] = '{data: joined, ok: 1'b1, last: in_last};
               phase_next       = upc_pkg::PH_IDLE;
               high_next        = 4'd0;
            end
            default: begin
               phase_next = upc_pkg::PH_IDLE;
               if (in_byte == upc_pkg::CH_PERCENT) begin
                  if (in_last) begin
                     beat_set.cnt     = 2'd1;
                     beat_set.beat[0] = '{data: 8'd0, ok: 1'b0, last: 1'b1};
                  end else begin
                     phase_next = upc_pkg::PH_HIGH;
                  end
               end else if (in_byte == upc_pkg::CH_PLUS) begin
                  beat_set.cnt     = 2'd1;
                  beat_set.beat[0] = '{data: upc_pkg::CH_SPACE, ok: 1'b1, last: in_last};
               end else begin
                  beat_set.cnt     = 2'd1;
                  beat_set.beat[0] = '{data: in_byte, ok: 1'b1, last: in_last};
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[src/url_percent_codec.sv]
// URL percent codec: turns a byte stream into its percent-encoded or decoded
// form, with the direction set by register 0 (decode_mode, bit 0; write it only
// while the codec is idle; a write also drops any half-read escape). A source
// byte is translated in the cycle it is accepted and its up to three result
// beats go to a beat buffer that drains into the single-beat result register one
// beat per clock unless the output stalls; each beat passes both registers.
// Bytes that give one result or none go at one per cycle without a stall; a
// %XX escape holds off the next byte until its last beat leaves the buffer.
`default_nettype none

`include "url_percent_codec_assert.svh"

module url_percent_codec #(
   parameter int unsigned ADDR_W = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   upc_req_if.sink                req_ch,
   upc_rsp_if.source              rsp_ch,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic                    mode_ff, mode_in;
   upc_pkg::phase_type      phase_ff, phase_in;
   logic [3:0]              high_ff, high_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic [1:0]              idx_ff, idx_in;
   upc_pkg::beat_type [upc_pkg::MAX_BEATS-1:0] beats_ff, beats_in;
   upc_pkg::beat_type       rsp_beat_ff, rsp_beat_in;
   logic                    rsp_vld_ff, rsp_vld_in;

   upc_pkg::beat_set_type   beat_set;
   upc_pkg::phase_type      phase_next;
   logic [3:0]              high_next;

   logic csr_wr, mode_hit, accept, out_load, emit;

   upc_xlate u_xlate (
      .decode_mode (mode_ff),
      .in_byte     (req_ch.in_byte),
      .in_last     (req_ch.in_last),
      .phase       (phase_ff),
      .high_digit  (high_ff),
      .beat_set    (beat_set),
      .phase_next  (phase_next),
      .high_next   (high_next)
   );

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign mode_hit   = csr_wr && (csr_paddr[ADDR_W-1:2] == '0);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[ADDR_W-1:2] == '0) ? {31'd0, mode_ff} : 32'd0;

   assign out_load     = !rsp_vld_ff || rsp_ch.ready;
   assign emit         = (cnt_ff != 2'd0) && out_load;
   // take a new byte once the buffered beats are gone or the last one leaves now
   assign req_ch.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && out_load);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      high_in  = high_ff;
      if (mode_hit) begin
         mode_in  = csr_pwdata[0];
         phase_in = upc_pkg::PH_IDLE;
         high_in  = 4'd0;
      end else if (accept) begin
         phase_in = phase_next;
         high_in  = high_next;
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      beats_in = beats_ff;
      if (accept) begin
         cnt_in   = beat_set.cnt;
         idx_in   = 2'd0;
         beats_in = beat_set.beat;
      end else if (emit) begin
         cnt_in = cnt_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_beat_in = rsp_beat_ff;
      rsp_vld_in  = rsp_vld_ff;
      if (emit) begin
         rsp_beat_in = beats_ff[idx_ff];
         rsp_vld_in  = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         phase_ff   <= upc_pkg::PH_IDLE;
         high_ff    <= 4'd0;
         cnt_ff     <= 2'd0;
         idx_ff     <= 2'd0;
         rsp_vld_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         high_ff    <= high_in;
         cnt_ff     <= cnt_in;
         idx_ff     <= idx_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      beats_ff    <= beats_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.out_byte  = rsp_beat_ff.data;
   assign rsp_ch.out_valid = rsp_beat_ff.ok;
   assign rsp_ch.out_last  = rsp_beat_ff.last;

   `UPC_ASSERT_ALWAYS(a_buf_in_range, clock, reset,
      ({1'b0, idx_ff} + {1'b0, cnt_ff}) <= 3'd3)
   `UPC_ASSERT_ALWAYS(a_encode_no_escape, clock, reset,
      mode_ff || (phase_ff == upc_pkg::PH_IDLE))
   `UPC_ASSERT_ALWAYS(a_invalid_closes, clock, reset,
      !rsp_ch.valid || rsp_ch.out_valid || rsp_ch.out_last)
   `UPC_ASSERT_NEXT(a_stall_holds_buf, clock, reset,
      rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid && $stable(rsp_beat_ff))

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the URL percent codec: stream stimulus, scoreboard and CSR writes.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] REG_MODE_ADDR = 3'd0;
   localparam logic       MODE_ENCODE   = 1'b0;
   localparam logic       MODE_DECODE   = 1'b1;
   localparam int         SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   upc_req_if req_if();
   upc_rsp_if rsp_if();

   // codec state as the bench sees it
   logic                mode_decode = MODE_ENCODE;
   upc_pkg::phase_type  esc_phase = upc_pkg::PH_IDLE;
   logic [3:0]          esc_high = 4'h0;
   upc_pkg::beat_type   pending_beats[$];

   int mismatch_count = 0;
   bit src_gaps = 1'b0;
   bit sink_gaps = 1'b0;
   int hold_request = 0;

   url_percent_codec dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // mostly back to back, often short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic is_unreserved(logic [7:0] c);
      if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
         return 1'b1;
      case (c)
         "-", "_", ".", "~", "=", "!", "*", "'", "(", ")", "&": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] hex_char_of(logic [3:0] v);
      return (v > 4'd9) ? {4'h0, v} + upc_pkg::HEX_ALPHA_OFS
                        : {4'h0, v} + upc_pkg::HEX_DIGIT_OFS;
   endfunction

   function automatic logic [7:0] digit_weight(logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A" + 8'd10;
      if (c >= "a" && c <= "z") return c - "a" + 8'd10;
      if (c >= "0" && c <= "9") return c - "0";
      return 8'd0;
   endfunction

   function automatic void expect_beat(logic [7:0] data, logic ok, logic last);
      upc_pkg::beat_type b;
      b.data = data;
      b.ok   = ok;
      b.last = last;
      pending_beats = {pending_beats, b};
   endfunction

   function automatic void translate_byte(logic [7:0] c, logic last);
      logic [7:0] w;
      if (mode_decode == MODE_ENCODE) begin
         if (is_unreserved(c)) begin
            expect_beat(c, 1'b1, last);
         end else if (c == upc_pkg::CH_SPACE) begin
            expect_beat(upc_pkg::CH_PLUS, 1'b1, last);
         end else begin
            expect_beat(upc_pkg::CH_PERCENT, 1'b1, 1'b0);
            expect_beat(hex_char_of(c[7:4]), 1'b1, 1'b0);
            expect_beat(hex_char_of(c[3:0]), 1'b1, last);
         end
      end else begin
         case (esc_phase)
            upc_pkg::PH_HIGH: begin
               if (last) begin
                  expect_beat(8'h00, 1'b0, 1'b1);
                  esc_phase = upc_pkg::PH_IDLE;
                  esc_high  = 4'h0;
               end else begin
                  w         = digit_weight(c);
                  esc_high  = w[3:0];
                  esc_phase = upc_pkg::PH_LOW;
               end
            end
            upc_pkg::PH_LOW: begin
               expect_beat({esc_high, 4'h0} + digit_weight(c), 1'b1, last);
               esc_phase = upc_pkg::PH_IDLE;
               esc_high  = 4'h0;
            end
            default: begin
               esc_phase = upc_pkg::PH_IDLE;
               if (c == upc_pkg::CH_PERCENT) begin
                  // escape cut short on the percent itself
                  if (last) expect_beat(8'h00, 1'b0, 1'b1);
                  else esc_phase = upc_pkg::PH_HIGH;
               end else if (c == upc_pkg::CH_PLUS) begin
                  expect_beat(upc_pkg::CH_SPACE, 1'b1, last);
               end else begin
                  expect_beat(c, 1'b1, last);
               end
            end
         endcase
      end
   endfunction

   // scoreboard: compare every result beat with the oldest expectation
   always @(posedge clock) begin
      upc_pkg::beat_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected result beat: out_byte %h", rsp_if.out_byte);
            mismatch_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_if.out_byte !== want.data) begin
               $error("out_byte: expected %h, actual %h", want.data, rsp_if.out_byte);
               mismatch_count++;
            end
            if (rsp_if.out_valid !== want.ok) begin
               $error("out_valid: expected %b, actual %b", want.ok, rsp_if.out_valid);
               mismatch_count++;
            end
            if (rsp_if.out_last !== want.last) begin
               $error("out_last: expected %b, actual %b", want.last, rsp_if.out_last);
               mismatch_count++;
            end
         end
      end
   end

   // result-side ready: random stalls, or one long hold when requested
   initial begin
      int stall;
      rsp_if.ready = 1'b1;
      forever begin
         @(posedge clock);
         stall = 0;
         if (hold_request != 0) begin
            stall = hold_request;
            hold_request = 0;
         end else if (sink_gaps) begin
            stall = pick_gap();
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      gap = src_gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= c;
      req_if.in_last <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      translate_byte(c, last);
   endtask

   // drop valid and hold until every expected beat is back, then let the pipe settle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      logic [31:0] readback;
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == REG_MODE_ADDR) begin
         mode_decode = data[0];
         esc_phase   = upc_pkg::PH_IDLE;
         esc_high    = 4'h0;
      end
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== {31'h0, mode_decode}) begin
         $error("decode_mode readback: expected %h, actual %h", {31'h0, mode_decode}, readback);
         mismatch_count++;
      end
   endtask

   function automatic logic [7:0] pick_encode_byte();
      string marks;
      marks = "-_.~=!*'()& +%";
      if ($urandom_range(0, 9) < 3) return marks[$urandom_range(0, marks.len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_digit();
      string hex_set;
      hex_set = "0123456789abcdefABCDEF";
      case ($urandom_range(0, 3))
         0, 1: return hex_set[$urandom_range(0, hex_set.len() - 1)];
         2: return 8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_encode_edges();
      logic [7:0] text[9];
      logic       ends[9];
      text = '{8'h00, 8'hFF, "A", "z", "9", "~", " ", "%", "/"};
      ends = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
      csr_write(REG_MODE_ADDR, {31'h0, MODE_ENCODE});
      for (int i = 0; i < 9; i++) send_byte(text[i], ends[i]);
   endtask

   task automatic test_decode_edges();
      logic [7:0] text[14];
      logic       ends[14];
      // valid escape, plus, letters past F, non-hex high digit, two cut-short escapes
      text = '{"%", "4", "a", "+", "%", "z", "Z", "%", "!", "G", "%", "%", "4", "%"};
      ends = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
               1'b1, 1'b0, 1'b1, 1'b0};
      csr_write(REG_MODE_ADDR, {31'h0, MODE_DECODE});
      for (int i = 0; i < 14; i++) send_byte(text[i], ends[i]);
      // leave an escape half read, then a mode write must drop it
      send_byte("7", 1'b0);
      csr_write(REG_MODE_ADDR, {31'h0, MODE_DECODE});
      send_byte("q", 1'b1);
   endtask

   task automatic test_encode_random(input int count);
      src_gaps  = 1'b1;
      sink_gaps = 1'b1;
      csr_write(REG_MODE_ADDR, {31'h0, MODE_ENCODE});
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_idle();
         send_byte(pick_encode_byte(), $urandom_range(0, 5) == 0);
      end
   endtask

   task automatic test_decode_strings(input int count);
      logic [7:0] text[$];
      logic [7:0] r;
      int         sent;
      int         parts;
      sent = 0;
      csr_write(REG_MODE_ADDR, {31'h0, MODE_DECODE});
      while (sent < count) begin
         text.delete();
         parts = $urandom_range(1, 6);
         for (int p = 0; p < parts; p++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  r = 8'($urandom_range(0, 255));
                  if (r == upc_pkg::CH_PERCENT) r = r ^ 8'h80;
                  text = {text, r};
               end
               5: text = {text, upc_pkg::CH_PLUS};
               default: begin
                  text = {text, upc_pkg::CH_PERCENT};
                  text = {text, pick_digit()};
                  text = {text, pick_digit()};
               end
            endcase
         end
         // now and then end the string inside an escape
         if ($urandom_range(0, 7) == 0) begin
            text = {text, upc_pkg::CH_PERCENT};
            if ($urandom_range(0, 1)) text = {text, pick_digit()};
         end
         foreach (text[i]) send_byte(text[i], i == text.size() - 1);
         sent += text.size();
      end
   endtask

   task automatic test_decode_noise(input int count);
      logic [7:0] c;
      csr_write(REG_MODE_ADDR, {31'h0, MODE_DECODE});
      for (int i = 0; i < count; i++) begin
         c = ($urandom_range(0, 4) == 0) ? upc_pkg::CH_PERCENT : 8'($urandom_range(0, 255));
         send_byte(c, $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic test_backpressure(input int count);
      src_gaps  = 1'b0;
      sink_gaps = 1'b0;
      csr_write(REG_MODE_ADDR, {31'h0, MODE_ENCODE});
      // hold the result side while bytes keep coming, so the input must stall
      hold_request = 200;
      for (int i = 0; i < count; i++)
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
   endtask

   task automatic test_streaming(input int count);
      src_gaps  = 1'b0;
      sink_gaps = 1'b0;
      csr_write(REG_MODE_ADDR, {31'h0, MODE_ENCODE});
      for (int i = 0; i < count; i++) send_byte(pick_encode_byte(), $urandom_range(0, 5) == 0);
      test_decode_strings(count);
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.in_byte = 8'h00;
      req_if.in_last = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_encode_edges();
      test_decode_edges();
      test_encode_random(100);
      test_decode_strings(110);
      test_decode_noise(40);
      test_backpressure(40);
      test_streaming(30);

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_beats.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
